// ===== rtl/core/bffs_pkg.sv =====
package bffs_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_START_CHAR = 2'd0;
    localparam logic [1:0] CFG_END_CHAR   = 2'd1;
    localparam logic [1:0] CFG_SEP_CHAR   = 2'd2;

    // reset values of the delimiter registers
    localparam logic [7:0] START_CHAR_RST = 8'd91;
    localparam logic [7:0] END_CHAR_RST   = 8'd93;
    localparam logic [7:0] SEP_CHAR_RST   = 8'd44;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // delimiter set
    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] end_char;
        logic [7:0] separator_char;
    } bffs_cfg_t;

    // one result word
    typedef struct packed {
        logic [2:0] field_index;
        logic [4:0] char_index;
        logic [7:0] out_char;
        logic       char_valid;
        logic       end_of_field;
        logic       end_of_frame;
        logic       frame_restart;
        logic       overflow;
    } bffs_res_t;

endpackage

// ===== rtl/core/bffs_cfg_regs.sv =====
module bffs_cfg_regs
    import bffs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output bffs_cfg_t             cfg
);

    bffs_cfg_t cfg_reg;
    bffs_cfg_t cfg_next;

    // decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_CHAR: cfg_next.start_char     = cfg_data;
                CFG_END_CHAR:   cfg_next.end_char       = cfg_data;
                CFG_SEP_CHAR:   cfg_next.separator_char = cfg_data;
                default:        cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_char     <= START_CHAR_RST;
            cfg_reg.end_char       <= END_CHAR_RST;
            cfg_reg.separator_char <= SEP_CHAR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/bffs_parser.sv =====
module bffs_parser
    import bffs_pkg::*;
#(
    parameter int MAX_FIELDS    = 6,
    parameter int MAX_FIELD_LEN = 32,
    parameter int MAX_PAYLOAD   = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  bffs_cfg_t  cfg,
    input  logic [7:0] byte_in,
    input  logic       fire,
    output logic       has_res,
    output bffs_res_t  res
);

    localparam int FC_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int CC_W = $clog2(MAX_FIELD_LEN + 1);
    localparam int PC_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [FC_W-1:0] FC_LAST = FC_W'(MAX_FIELDS - 1);
    localparam logic [CC_W-1:0] CC_FULL = CC_W'(MAX_FIELD_LEN);
    localparam logic [PC_W-1:0] PC_FULL = PC_W'(MAX_PAYLOAD);

    logic            in_frame_reg, in_frame_next;
    logic [FC_W-1:0] fc_reg, fc_next;
    logic [CC_W-1:0] cc_reg, cc_next;
    logic [PC_W-1:0] pc_reg, pc_next;

    logic is_start;
    logic is_end;
    logic is_sep;

    // delimiter match, start wins over end, end over separator
    assign is_start = (byte_in == cfg.start_char);
    assign is_end   = (byte_in == cfg.end_char);
    assign is_sep   = (byte_in == cfg.separator_char);

    // classify the byte and update the frame counters
    always_comb
    begin
        in_frame_next = in_frame_reg;
        fc_next       = fc_reg;
        cc_next       = cc_reg;
        pc_next       = pc_reg;
        has_res       = 1'b0;
        res           = '0;
        res.field_index = 3'(fc_reg);

        if (is_start)
        begin
            in_frame_next     = 1'b1;
            fc_next           = '0;
            cc_next           = '0;
            pc_next           = '0;
            has_res           = in_frame_reg;
            res.field_index   = '0;
            res.frame_restart = 1'b1;
        end
        else if (in_frame_reg)
        begin
            has_res = 1'b1;
            if (is_end)
            begin
                res.end_of_field = 1'b1;
                res.end_of_frame = 1'b1;
                in_frame_next    = 1'b0;
                fc_next          = '0;
                cc_next          = '0;
                pc_next          = '0;
            end
            else if (pc_reg == PC_FULL)
            begin
                res.overflow = 1'b1;
            end
            else if (is_sep)
            begin
                if (fc_reg == FC_LAST)
                begin
                    res.overflow = 1'b1;
                end
                else
                begin
                    res.end_of_field = 1'b1;
                    fc_next          = fc_reg + 1'b1;
                    cc_next          = '0;
                    pc_next          = pc_reg + 1'b1;
                end
            end
            else if (cc_reg == CC_FULL)
            begin
                res.overflow = 1'b1;
            end
            else
            begin
                res.char_index = 5'(cc_reg);
                res.out_char   = byte_in;
                res.char_valid = 1'b1;
                cc_next        = cc_reg + 1'b1;
                pc_next        = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            fc_reg       <= '0;
            cc_reg       <= '0;
            pc_reg       <= '0;
        end
        else if (fire)
        begin
            in_frame_reg <= in_frame_next;
            fc_reg       <= fc_next;
            cc_reg       <= cc_next;
            pc_reg       <= pc_next;
        end
    end

endmodule

// ===== rtl/core/bracket_frame_field_splitter_core.sv =====
// a byte goes from the input register via the parse into the result register
// throughput: one byte per cycle; a byte with a result waits while the result
// register holds a stalled word; the parse is a single pass of compares and
// counter updates between the input register and the result register
// bytes that give no result leave the input register even while a result waits
// reset: asynchronous, clears the frame state and the valid flags and loads
// the delimiters with '[', ']' and ','
module bracket_frame_field_splitter_core
    import bffs_pkg::*;
#(
    parameter int MAX_FIELDS    = 6,
    parameter int MAX_FIELD_LEN = 32,
    parameter int MAX_PAYLOAD   = 128
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            field_index,
    output logic [4:0]            char_index,
    output logic [7:0]            out_char,
    output logic                  char_valid,
    output logic                  end_of_field,
    output logic                  end_of_frame,
    output logic                  frame_restart,
    output logic                  overflow
);

    bffs_cfg_t  cfg;
    bffs_res_t  res;
    logic       has_res;
    logic       fire;
    logic       out_free;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    bffs_res_t  out_res_reg;

    bffs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bffs_parser #(
        .MAX_FIELDS    (MAX_FIELDS),
        .MAX_FIELD_LEN (MAX_FIELD_LEN),
        .MAX_PAYLOAD   (MAX_PAYLOAD)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .byte_in (in_byte_reg),
        .fire    (fire),
        .has_res (has_res),
        .res     (res)
    );

    // handshake between input register and result register
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && (out_free || !has_res);
    assign in_stall = in_valid_reg && !fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && has_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && fire && has_res)
        begin
            out_res_reg <= res;
        end
    end

    // result word ports
    assign out_valid     = out_valid_reg;
    assign field_index   = out_res_reg.field_index;
    assign char_index    = out_res_reg.char_index;
    assign out_char      = out_res_reg.out_char;
    assign char_valid    = out_res_reg.char_valid;
    assign end_of_field  = out_res_reg.end_of_field;
    assign end_of_frame  = out_res_reg.end_of_frame;
    assign frame_restart = out_res_reg.frame_restart;
    assign overflow      = out_res_reg.overflow;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import bffs_pkg::*;

    localparam int FIELD_LIMIT   = 6;
    localparam int LEN_LIMIT     = 32;
    localparam int PAYLOAD_LIMIT = 128;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_WORDS   = 75;
    localparam int REPORT_MAX    = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            field_index;
    logic [4:0]            char_index;
    logic [7:0]            out_char;
    logic                  char_valid;
    logic                  end_of_field;
    logic                  end_of_frame;
    logic                  frame_restart;
    logic                  overflow;

    bracket_frame_field_splitter_core #(
        .MAX_FIELDS    (FIELD_LIMIT),
        .MAX_FIELD_LEN (LEN_LIMIT),
        .MAX_PAYLOAD   (PAYLOAD_LIMIT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .field_index   (field_index),
        .char_index    (char_index),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .end_of_field  (end_of_field),
        .end_of_frame  (end_of_frame),
        .frame_restart (frame_restart),
        .overflow      (overflow)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // parser copy: delimiters and frame state
    logic [7:0] dl_start = START_CHAR_RST;
    logic [7:0] dl_end   = END_CHAR_RST;
    logic [7:0] dl_sep   = SEP_CHAR_RST;
    logic       frame_open = 1'b0;
    int         field_cnt = 0;
    int         pos_cnt = 0;
    int         payload_cnt = 0;

    bffs_res_t  words_due[$];
    int         words_pushed = 0;
    int         mismatch_cnt = 0;
    int         fail_cnt = 0;
    int         quiet_cycles = 0;

    // directed word typed in by hand, set together with the byte
    logic       hand_typed = 1'b0;
    bffs_res_t  hand_word = '0;

    bffs_res_t  pred_word;
    logic       pred_has;
    bffs_res_t  due_word;
    bffs_res_t  seen_word;
    logic       took_in;
    logic       took_out;

    typedef struct {
        logic [7:0] rx;
        logic       typed;
        bffs_res_t  word;
    } step_t;

    step_t      script[$];
    int         burst_left = 0;
    int         stall_mode = 0;
    int         stall_timer = 0;

    function automatic bffs_res_t mk(input int f, input int p, input int c, input int v,
                                     input int efld, input int efrm, input int rs,
                                     input int ov);
        bffs_res_t w;
        w.field_index   = f[2:0];
        w.char_index    = p[4:0];
        w.out_char      = c[7:0];
        w.char_valid    = v[0];
        w.end_of_field  = efld[0];
        w.end_of_frame  = efrm[0];
        w.frame_restart = rs[0];
        w.overflow      = ov[0];
        return w;
    endfunction

    // parse one byte: update the frame state, give the word it causes if any
    function automatic void parse_byte(input logic [7:0] b, output logic has,
                                       output bffs_res_t w);
        w   = '0;
        has = 1'b0;
        if (b == dl_start)
        begin
            has = frame_open;
            w.frame_restart = frame_open;
            frame_open  = 1'b1;
            field_cnt   = 0;
            pos_cnt     = 0;
            payload_cnt = 0;
        end
        else if (!frame_open)
        begin
            has = 1'b0;
        end
        else if (b == dl_end)
        begin
            has = 1'b1;
            w.field_index  = field_cnt[2:0];
            w.end_of_field = 1'b1;
            w.end_of_frame = 1'b1;
            frame_open  = 1'b0;
            field_cnt   = 0;
            pos_cnt     = 0;
            payload_cnt = 0;
        end
        else if (payload_cnt >= PAYLOAD_LIMIT)
        begin
            has = 1'b1;
            w.field_index = field_cnt[2:0];
            w.overflow    = 1'b1;
        end
        else if (b == dl_sep)
        begin
            has = 1'b1;
            w.field_index = field_cnt[2:0];
            if (field_cnt + 1 >= FIELD_LIMIT)
            begin
                w.overflow = 1'b1;
            end
            else
            begin
                w.end_of_field = 1'b1;
                field_cnt   = field_cnt + 1;
                pos_cnt     = 0;
                payload_cnt = payload_cnt + 1;
            end
        end
        else if (pos_cnt >= LEN_LIMIT)
        begin
            has = 1'b1;
            w.field_index = field_cnt[2:0];
            w.overflow    = 1'b1;
        end
        else
        begin
            has = 1'b1;
            w.field_index = field_cnt[2:0];
            w.char_index  = pos_cnt[4:0];
            w.out_char    = b;
            w.char_valid  = 1'b1;
            pos_cnt     = pos_cnt + 1;
            payload_cnt = payload_cnt + 1;
        end
    endfunction

    // monitor: check result words, predict from accepted bytes, track writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_in  = in_valid && !in_stall;
            took_out = out_valid && !out_stall;
            if (took_out)
            begin
                seen_word.field_index   = field_index;
                seen_word.char_index    = char_index;
                seen_word.out_char      = out_char;
                seen_word.char_valid    = char_valid;
                seen_word.end_of_field  = end_of_field;
                seen_word.end_of_frame  = end_of_frame;
                seen_word.frame_restart = frame_restart;
                seen_word.overflow      = overflow;
                if (words_due.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                    begin
                        $write("unexpected word: fld=%0d pos=%0d chr=%02h v=%b",
                               seen_word.field_index, seen_word.char_index,
                               seen_word.out_char, seen_word.char_valid);
                        $display(" eofld=%b eofrm=%b rs=%b ovf=%b",
                                 seen_word.end_of_field, seen_word.end_of_frame,
                                 seen_word.frame_restart, seen_word.overflow);
                    end
                end
                else
                begin
                    due_word = words_due.pop_front();
                    if (due_word.field_index   !== seen_word.field_index   ||
                        due_word.char_index    !== seen_word.char_index    ||
                        due_word.out_char      !== seen_word.out_char      ||
                        due_word.char_valid    !== seen_word.char_valid    ||
                        due_word.end_of_field  !== seen_word.end_of_field  ||
                        due_word.end_of_frame  !== seen_word.end_of_frame  ||
                        due_word.frame_restart !== seen_word.frame_restart ||
                        due_word.overflow      !== seen_word.overflow)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                        begin
                            $write("mismatch: exp fld=%0d pos=%0d chr=%02h v=%b",
                                   due_word.field_index, due_word.char_index,
                                   due_word.out_char, due_word.char_valid);
                            $write(" eofld=%b eofrm=%b rs=%b ovf=%b",
                                   due_word.end_of_field, due_word.end_of_frame,
                                   due_word.frame_restart, due_word.overflow);
                            $write(" | got fld=%0d pos=%0d chr=%02h v=%b",
                                   seen_word.field_index, seen_word.char_index,
                                   seen_word.out_char, seen_word.char_valid);
                            $display(" eofld=%b eofrm=%b rs=%b ovf=%b",
                                     seen_word.end_of_field, seen_word.end_of_frame,
                                     seen_word.frame_restart, seen_word.overflow);
                        end
                    end
                end
            end
            if (took_in)
            begin
                parse_byte(rx_byte, pred_has, pred_word);
                if (hand_typed)
                begin
                    words_due.push_back(hand_word);
                    words_pushed++;
                end
                else if (pred_has)
                begin
                    words_due.push_back(pred_word);
                    words_pushed++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_CHAR: dl_start = cfg_data;
                    CFG_END_CHAR:   dl_end   = cfg_data;
                    CFG_SEP_CHAR:   dl_sep   = cfg_data;
                    default: ;
                endcase
            end
            if (took_in || took_out)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // watchdog on cycles with no word moving
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("bracket_frame_field_splitter_core test failed");
        $finish;
    end

    // receiver stall pattern: none, light random, heavy random
    always @(negedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(0, 2);
            stall_timer = $urandom_range(20, 120);
        end
        else
        begin
            stall_timer = stall_timer - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // send one byte, bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input bffs_res_t w = '0);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                rx_byte  <= 8'($urandom_range(0, 255));
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        hand_typed = typed;
        hand_word  = w;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    // hold the sender until every word due has come, then let the pipe settle
    task automatic drain_words();
        @(negedge clk);
        in_valid <= 1'b0;
        hand_typed = 1'b0;
        while (words_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_delims(input logic [7:0] s, input logic [7:0] e, input logic [7:0] p);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_CHAR;
        cfg_data  <= s;
        @(negedge clk);
        cfg_index <= CFG_END_CHAR;
        cfg_data  <= e;
        @(negedge clk);
        cfg_index <= CFG_SEP_CHAR;
        cfg_data  <= p;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // payload byte that is none of the delimiters, now and then any byte
    function automatic logic [7:0] pick_payload();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) != 0)
        begin
            while (v == dl_start || v == dl_end || v == dl_sep)
                v = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    task automatic send_field_bytes(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_byte(pick_payload());
    endtask

    // one random frame: mostly well formed, some noise and broken frames
    task automatic send_frame(input bit heavy);
        int kind;
        int nf;
        int f;
        int len;
        kind = heavy ? 9 : $urandom_range(0, 9);
        if (kind == 0)
        begin
            // noise, any byte values
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (kind == 1)
        begin
            // frame cut short by a restart
            send_byte(dl_start);
            send_field_bytes($urandom_range(0, 4));
        end
        send_byte(dl_start);
        nf = heavy ? 5 : $urandom_range(1, 7);
        for (f = 0; f < nf; f++)
        begin
            if (f > 0)
                send_byte(dl_sep);
            if (heavy)
                len = $urandom_range(30, 34);
            else if ($urandom_range(0, 7) == 0)
                len = $urandom_range(28, 36);
            else
                len = $urandom_range(0, 5);
            send_field_bytes(len);
        end
        // missing end now and then
        if (kind != 2)
            send_byte(dl_end);
        if ($urandom_range(0, 5) == 0)
            send_byte(dl_end);
    endtask

    task automatic row(input logic [7:0] b, input logic typed, input bffs_res_t w);
        step_t s;
        s.rx    = b;
        s.typed = typed;
        s.word  = w;
        script.push_back(s);
    endtask

    // main sequence
    initial
    begin
        int i;
        int ph;
        int base;
        bit heavy_done;
        logic [7:0] ps [6];
        logic [7:0] pe [6];
        logic [7:0] pp [6];

        ps = '{8'd91, 8'h00, 8'hFF, 8'h3C, 8'h02, 8'h00};
        pe = '{8'd93, 8'hFF, 8'h00, 8'h3C, 8'h03, 8'h00};
        pp = '{8'd44, 8'h80, 8'h01, 8'h3C, 8'h03, 8'h00};

        // directed script with reset delimiters
        row(8'h41, 1'b0, '0);
        row(8'h5D, 1'b0, '0);
        row(8'h2C, 1'b0, '0);
        row(8'h5B, 1'b0, '0);
        row(8'h00, 1'b1, mk(0, 0, 8'h00, 1, 0, 0, 0, 0));
        row(8'hFF, 1'b1, mk(0, 1, 8'hFF, 1, 0, 0, 0, 0));
        row(8'h2C, 1'b1, mk(0, 0, 0, 0, 1, 0, 0, 0));
        row(8'h41, 1'b1, mk(1, 0, 8'h41, 1, 0, 0, 0, 0));
        row(8'h5B, 1'b1, mk(0, 0, 0, 0, 0, 0, 1, 0));
        row(8'h42, 1'b1, mk(0, 0, 8'h42, 1, 0, 0, 0, 0));
        row(8'h5D, 1'b1, mk(0, 0, 0, 0, 1, 1, 0, 0));
        row(8'h80, 1'b0, '0);
        row(8'h5B, 1'b0, '0);
        for (i = 0; i < FIELD_LIMIT - 1; i++)
            row(8'h2C, 1'b1, mk(i, 0, 0, 0, 1, 0, 0, 0));
        // separator beyond the last field gives an overflow word
        row(8'h2C, 1'b1, mk(FIELD_LIMIT - 1, 0, 0, 0, 0, 0, 0, 1));
        row(8'h7F, 1'b0, '0);
        row(8'h5D, 1'b1, mk(FIELD_LIMIT - 1, 0, 0, 0, 1, 1, 0, 0));

        // reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[k])
            send_byte(script[k].rx, script[k].typed, script[k].word);

        // random phases, one delimiter set each
        ps[5] = 8'($urandom_range(0, 255));
        pe[5] = 8'($urandom_range(0, 255));
        pp[5] = 8'($urandom_range(0, 255));
        for (ph = 0; ph < 6; ph++)
        begin
            drain_words();
            set_delims(ps[ph], pe[ph], pp[ph]);
            base = words_pushed;
            heavy_done = 1'b0;
            while (words_pushed - base < PHASE_WORDS)
            begin
                if (!heavy_done && (ph == 0) && (words_pushed - base >= 40))
                begin
                    send_frame(1'b1);
                    heavy_done = 1'b1;
                end
                else
                begin
                    send_frame(1'b0);
                end
                if ($urandom_range(0, 14) == 0)
                    drain_words();
            end
        end

        // wind down
        drain_words();
        repeat (8) @(posedge clk);
        fail_cnt = fail_cnt + words_due.size();
        if (mismatch_cnt == 0 && fail_cnt == 0)
            $display("bracket_frame_field_splitter_core test passed");
        else
            $display("bracket_frame_field_splitter_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bffs_pkg.sv
rtl/core/bffs_cfg_regs.sv
rtl/core/bffs_parser.sv
rtl/core/bracket_frame_field_splitter_core.sv
tb/tb_top.sv
